@@ src/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Transaction payload types, operation codes and character constants shared
// by the console writer RTL.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int NUMBER_W   = 64;
  localparam int CURSOR_W   = 11;
  localparam int DEC_DIGITS = 20;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_WRITE_CHAR = 2'd0;
  localparam logic [1:0] FUNC_WRITE_DEC  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR      = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  typedef struct packed {
    logic [1:0]          func;
    logic [7:0]          char_code;
    logic [NUMBER_W-1:0] number;
  } cmd_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic                scrolled;
  } res_t;

endpackage
`default_nettype wire

@@ src/text_console_writer.sv @@
// A plain character write stores its cell and moves the cursor, then shows its result. With
// the cursor at the end of the buffer a write scrolls the buffer up one row first; a clear
// sweeps every cell. A decimal write steps over each leading zero position, counts each
// printed digit by repeated subtraction and writes it, then shows the result, plus any scroll.
// One transaction at a time. Reset clears the cursor, sequencer and result valid flag, sets
// the attribute to 7, and leaves the cells undefined.
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Keeps a ROWS x COLUMNS buffer of 16-bit cells and a linear cursor, and runs
// character writes, decimal number writes and screen clears under a small
// sequencer with one memory port pair and one shared compare-and-subtract unit.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Configuration: text attribute register.
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  // Command channel.
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  input  wire cmd_t       cmd,
  // Result channel.
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res
);

  // Buffer geometry. The cursor can hold the cell count itself, so it is one
  // step wider than the memory address when the count is a power of two.
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [CUR_W-1:0] CELL_N      = CUR_W'(CELLS);
  localparam logic [CUR_W-1:0] CELL_LAST   = CUR_W'(CELLS - 1);
  localparam logic [CUR_W-1:0] COLS_N      = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] LAST_ROW    = CUR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PUT    = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  // Powers of ten for the decimal digit positions, lowest position first.
  function automatic logic [NUMBER_W-1:0] pow10(input logic [4:0] idx);
    case (idx)
      5'd0:    pow10 = 64'd1;
      5'd1:    pow10 = 64'd10;
      5'd2:    pow10 = 64'd100;
      5'd3:    pow10 = 64'd1_000;
      5'd4:    pow10 = 64'd10_000;
      5'd5:    pow10 = 64'd100_000;
      5'd6:    pow10 = 64'd1_000_000;
      5'd7:    pow10 = 64'd10_000_000;
      5'd8:    pow10 = 64'd100_000_000;
      5'd9:    pow10 = 64'd1_000_000_000;
      5'd10:   pow10 = 64'd10_000_000_000;
      5'd11:   pow10 = 64'd100_000_000_000;
      5'd12:   pow10 = 64'd1_000_000_000_000;
      5'd13:   pow10 = 64'd10_000_000_000_000;
      5'd14:   pow10 = 64'd100_000_000_000_000;
      5'd15:   pow10 = 64'd1_000_000_000_000_000;
      5'd16:   pow10 = 64'd10_000_000_000_000_000;
      5'd17:   pow10 = 64'd100_000_000_000_000_000;
      5'd18:   pow10 = 64'd1_000_000_000_000_000_000;
      5'd19:   pow10 = 64'd10_000_000_000_000_000_000;
      default: pow10 = 64'd1;
    endcase
  endfunction

  logic [2:0]       state;
  logic [7:0]       attr;
  logic [CUR_W-1:0] cursor;
  logic [COL_W-1:0] col;          // cursor modulo COLUMNS, kept alongside the cursor
  logic [CUR_W-1:0] ptr;          // walking address for scroll and clear sweeps
  logic             pend_valid;   // a copied cell waits to be written
  logic [ADDR_W-1:0] pend_addr;
  logic [7:0]       ch;           // character being written
  logic             is_dec;       // the character comes from a decimal write
  logic             scrolled;

  // Decimal conversion: one digit position at a time, most significant first,
  // by repeated compare and subtract against that position's power of ten.
  logic [NUMBER_W-1:0] dval;
  logic [4:0]          pidx;
  logic [3:0]          digit;
  logic                lead_seen;   // a digit of the number has been printed
  logic [NUMBER_W-1:0] pow;
  logic [NUMBER_W:0]   diff;

  // Cell buffer with one write port and one registered read port.
  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;

  logic [31:0] cursor_ext;

  assign cmd_ready = (state == S_IDLE);
  assign rd_addr   = ptr[ADDR_W-1:0];
  assign cursor_ext = 32'(cursor);

  // The shared unit: the borrow out of the subtraction tells whether the
  // power of ten still fits into what is left of the number.
  assign pow  = pow10(pidx);
  assign diff = {1'b0, dval} - {1'b0, pow};

  // Memory write selection. A pending copy from the previous cycle has the
  // port first; otherwise sweeps write spaces and a character write stores
  // its cell at the cursor.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor[ADDR_W-1:0];
    mem_wdata = {attr, ch};
    if (pend_valid) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = rd_data;
    end else if (state == S_FILL || state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = ptr[ADDR_W-1:0];
      mem_wdata = {attr, SPACE_CODE};
    end else if (state == S_PUT && cursor != CELL_N && ch != NEWLINE_CODE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= '0;
      col        <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded or kept below.
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            scrolled <= 1'b0;
            ch       <= cmd.char_code;
            is_dec   <= (cmd.func == FUNC_WRITE_DEC);
            case (cmd.func)
              FUNC_WRITE_CHAR: begin
                state <= S_PUT;
              end
              FUNC_WRITE_DEC: begin
                // Zero falls out of the walk as a single '0' at the lowest position.
                dval      <= cmd.number;
                pidx      <= 5'(DEC_DIGITS - 1);
                digit     <= 4'd0;
                lead_seen <= 1'b0;
                state     <= S_DIV;
              end
              FUNC_CLEAR: begin
                ptr   <= '0;
                state <= S_CLEAR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_DIV: begin
          if (!diff[NUMBER_W]) begin
            // The power still fits: take it off and count one more.
            dval  <= diff[NUMBER_W-1:0];
            digit <= digit + 4'd1;
          end else if (digit != 4'd0 || lead_seen || pidx == 5'd0) begin
            ch        <= DIGIT_ZERO + {4'd0, digit};
            lead_seen <= 1'b1;
            state     <= S_PUT;
          end else begin
            // Leading zero: nothing is printed for this position.
            pidx <= pidx - 5'd1;
          end
        end

        S_EMIT: begin
          // Step down to the next digit position once a digit has been stored.
          if (pidx == 5'd0) begin
            state <= S_DONE;
          end else begin
            pidx  <= pidx - 5'd1;
            digit <= 4'd0;
            state <= S_DIV;
          end
        end

        S_PUT: begin
          if (cursor == CELL_N) begin
            // Cursor sits past the last cell: scroll up one row first.
            ptr   <= COLS_N;
            state <= S_COPY;
          end else begin
            if (ch == NEWLINE_CODE) begin
              cursor <= cursor - CUR_W'(col) + COLS_N;
              col    <= '0;
            end else begin
              cursor <= cursor + CUR_W'(1);
              col    <= (col == COL_LAST) ? '0 : col + COL_W'(1);
            end
            state <= is_dec ? S_EMIT : S_DONE;
          end
        end

        S_COPY: begin
          // Read one cell per cycle; its write to the row above lands in the
          // following cycle.
          if (ptr != CELL_N) begin
            pend_valid <= 1'b1;
            pend_addr  <= ADDR_W'(ptr - COLS_N);
            ptr        <= ptr + CUR_W'(1);
          end else begin
            pend_valid <= 1'b0;
            ptr        <= LAST_ROW;
            state      <= S_FILL;
          end
        end

        S_FILL: begin
          if (ptr == CELL_LAST) begin
            cursor   <= LAST_ROW;
            scrolled <= 1'b1;
            state    <= S_PUT;
          end else begin
            ptr <= ptr + CUR_W'(1);
          end
        end

        S_CLEAR: begin
          if (ptr == CELL_LAST) begin
            cursor <= '0;
            col    <= '0;
            state  <= S_DONE;
          end else begin
            ptr <= ptr + CUR_W'(1);
          end
        end

        S_DONE: begin
          // Hold the finished result until the output register is free.
          if (!res_valid || res_ready) begin
            res.cursor_pos <= cursor_ext[CURSOR_W-1:0];
            res.scrolled   <= scrolled;
            res_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives character, decimal and clear transactions into the console writer
// through a short directed sequence and three random phases with different
// idle patterns. Results are checked against the typed values of directed rows
// or a cursor tracker with the block's scroll, newline and digit rules.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Opcode that the block must treat as a no-op. It has no name in the package.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 580;
  // A scroll or a clear walks the whole buffer and a 20-digit number repeats
  // the subtraction for each digit, so one transaction may run long.
  localparam int unsigned STALL_LIMIT     = 20000;
  localparam int unsigned SETTLE_CYCLES   = 4000;
  localparam int unsigned HOLD_CYCLES     = 500;
  localparam int unsigned REPORT_MAX      = 10;

  typedef struct {
    cmd_t        cmd;
    int unsigned reps;
    bit          typed;
    res_t        typed_res;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Cursor tracker. Cell contents and the attribute never reach the result
  // port, so only the cursor is kept.
  int unsigned con_cursor = 0;

  res_t        pending_results[$];
  stim_row_t   stim_rows[$];
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          full_rate      = 1'b0;
  logic        hold_active    = 1'b0;
  int unsigned quiet_cycles   = 0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One character through the console. A cursor parked at the end of the
  // buffer forces a scroll first; a newline then jumps to the next row start,
  // any other byte lands in a cell and advances the cursor.
  function automatic bit console_put_char(input logic [7:0] ch);
    bit did_scroll;
    did_scroll = 1'b0;
    if (con_cursor >= CELLS) begin
      con_cursor = (con_cursor > COLUMNS) ? con_cursor - COLUMNS : 0;
      did_scroll = 1'b1;
    end
    if (ch == NEWLINE_CODE) begin
      con_cursor = (con_cursor / COLUMNS + 1) * COLUMNS;
      if (con_cursor > CELLS)
        con_cursor = CELLS;
    end else begin
      con_cursor++;
    end
    return did_scroll;
  endfunction

  // Decimal digits go out most significant first through the character path.
  // Zero still prints one digit.
  function automatic bit console_put_number(input logic [NUMBER_W-1:0] value);
    logic [3:0]          digit [DEC_DIGITS];
    logic [NUMBER_W-1:0] rest;
    int                  count;
    bit                  did_scroll;
    rest       = value;
    count      = 0;
    did_scroll = 1'b0;
    if (rest == 0)
      return console_put_char(DIGIT_ZERO);
    while (rest != 0 && count < DEC_DIGITS) begin
      digit[count] = 4'(rest % 10);
      rest         = rest / 10;
      count++;
    end
    while (count > 0) begin
      count--;
      if (console_put_char(DIGIT_ZERO + digit[count]))
        did_scroll = 1'b1;
    end
    return did_scroll;
  endfunction

  function automatic res_t console_apply(input cmd_t c);
    res_t r;
    bit   did_scroll;
    did_scroll = 1'b0;
    case (c.func)
      FUNC_WRITE_CHAR: begin
        did_scroll = console_put_char(c.char_code);
      end
      FUNC_WRITE_DEC: begin
        did_scroll = console_put_number(c.number);
      end
      FUNC_CLEAR: begin
        con_cursor = 0;
      end
      default: begin
      end
    endcase
    r.cursor_pos = con_cursor[CURSOR_W-1:0];
    r.scrolled   = did_scroll;
    return r;
  endfunction

  // Offers one transaction and returns at the edge where it is taken. Valid is
  // only dropped while the sender idles, so back-to-back transactions keep it
  // high without a lower/raise pair in one time step.
  task automatic push_cmd(input cmd_t c, input bit typed, input res_t typed_res);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready)
      @(posedge clk);
    predicted = console_apply(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // The attribute only changes while nothing is in flight.
  task automatic write_attribute(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] func, input logic [7:0] ch,
                         input logic [NUMBER_W-1:0] num, input int unsigned reps,
                         input bit typed, input int unsigned pos, input bit scr);
    stim_row_t row;
    row.cmd.func             = func;
    row.cmd.char_code        = ch;
    row.cmd.number           = num;
    row.reps                 = reps;
    row.typed                = typed;
    row.typed_res.cursor_pos = pos[CURSOR_W-1:0];
    row.typed_res.scrolled   = scr;
    stim_rows.push_back(row);
  endtask

  // Random transactions come in runs: text, newline runs that push the cursor
  // to the bottom so that scrolls keep happening, decimal numbers of every
  // length, occasional clears and a sprinkle of the unused opcode. Unused
  // opcodes are not counted, since the block does nothing with them.
  task automatic run_random(input int unsigned n_items);
    int unsigned issued;
    int unsigned pick;
    int unsigned run_len;
    cmd_t        c;
    res_t        none;
    issued = 0;
    none   = '0;
    while (issued < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        run_len = 1;
      else if (pick < 7)
        run_len = $urandom_range(1, 2);
      else if (pick < 17)
        run_len = $urandom_range(1, 12);
      else if (pick < 32)
        run_len = $urandom_range(1, 3);
      else
        run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        c.char_code = 8'($urandom);
        c.number    = {$urandom, $urandom} >> $urandom_range(0, NUMBER_W - 1);
        if (pick < 4) begin
          c.func = FUNC_CLEAR;
        end else if (pick < 7) begin
          c.func = FUNC_UNUSED;
        end else if (pick < 17) begin
          c.func      = FUNC_WRITE_CHAR;
          c.char_code = NEWLINE_CODE;
        end else if (pick < 32) begin
          c.func = FUNC_WRITE_DEC;
        end else begin
          c.func = FUNC_WRITE_CHAR;
        end
        push_cmd(c, 1'b0, none);
        if (c.func != FUNC_UNUSED)
          issued++;
      end
    end
  endtask

  // Receiver side: random back-pressure, overridden by the long hold-off.
  always @(posedge clk) begin
    res_ready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long hold-off in the full-rate phase. The sender keeps offering, so the
  // block has to park its result and stall the command channel.
  initial begin
    wait (full_rate);
    repeat (40) @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  task automatic note_failure(input string msg);
    if (fail_count < REPORT_MAX)
      $display("%s", msg);
    fail_count++;
  endtask

  // Result checker. Sampling happens at the clock edge, before any register
  // of the block or of the testbench moves.
  always @(posedge clk) begin : check_result
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: cursor_pos=%0d scrolled=%0b",
                               res.cursor_pos, res.scrolled));
      end else begin
        want = pending_results.pop_front();
        if (res.cursor_pos !== want.cursor_pos || res.scrolled !== want.scrolled)
          note_failure($sformatf(
            "result mismatch: cursor_pos exp %0d got %0d, scrolled exp %0b got %0b",
            want.cursor_pos, res.cursor_pos, want.scrolled, res.scrolled));
      end
    end
  end

  // Watchdog: a run of cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the sender idling lightly and the receiver
    // stalling often. The cell buffer is unknown after reset, so a clear
    // comes before anything can scroll.
    send_idle_pct = 10;
    recv_idle_pct = 68;
    write_attribute(8'h00);

    // Unused opcode right after reset: cursor stays at zero.
    add_row(FUNC_UNUSED,     8'hA5, 64'h0, 1, 1'b1, 0, 1'b0);
    add_row(FUNC_WRITE_CHAR, 8'h41, 64'h0, 1, 1'b1, 1, 1'b0);
    add_row(FUNC_CLEAR,      8'h00, 64'h0, 1, 1'b1, 0, 1'b0);
    // Lowest and highest character byte.
    add_row(FUNC_WRITE_CHAR, 8'h00, 64'h0, 1, 1'b1, 1, 1'b0);
    add_row(FUNC_WRITE_CHAR, 8'hFF, 64'h0, 1, 1'b1, 2, 1'b0);
    // Zero prints one digit; the largest number prints twenty.
    add_row(FUNC_WRITE_DEC,  8'h00, 64'h0, 1, 1'b1, 3, 1'b0);
    add_row(FUNC_WRITE_DEC,  8'hFF, {NUMBER_W{1'b1}}, 1, 1'b1, 23, 1'b0);
    add_row(FUNC_UNUSED,     8'h5A, 64'h0, 1, 1'b1, 23, 1'b0);
    // Newlines down to the last row, then a newline on the last row, which
    // parks the cursor at the end without scrolling.
    add_row(FUNC_WRITE_CHAR, NEWLINE_CODE, 64'h0, ROWS, 1'b0, 0, 1'b0);
    // Writes from the parked position scroll first: a plain character, a
    // newline and a number whose first digit triggers the scroll.
    add_row(FUNC_WRITE_CHAR, 8'h78, 64'h0, 1, 1'b0, 0, 1'b0);
    add_row(FUNC_WRITE_CHAR, NEWLINE_CODE, 64'h0, 2, 1'b0, 0, 1'b0);
    add_row(FUNC_WRITE_DEC,  8'h00, 64'd12345, 1, 1'b0, 0, 1'b0);
    add_row(FUNC_CLEAR,      8'hFF, 64'h0, 1, 1'b1, 0, 1'b0);

    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps)
        push_cmd(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].typed_res);
    end
    drain_results();

    // Random phase one: same idle pattern, attribute at its top value.
    write_attribute(8'hFF);
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Random phase two: the sender idles often, the receiver rarely.
    send_idle_pct = 68;
    recv_idle_pct = 10;
    write_attribute(8'($urandom));
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Random phase three: full rate on both sides, with one long hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_attribute(8'($urandom));
    full_rate = 1'b1;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // Give a stray extra result time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tcw_pkg.sv
src/text_console_writer.sv
test/tb_top.sv
